// ===== hdl/bas_pkg.sv =====
// Shared types, constants and helpers for the bracket-aware splitter.
// No dependencies; included first by every other file.
package bas_pkg;

	localparam int SYM_W       = 8;
	localparam int SEG_START_W = 12;
	localparam int SEG_LEN_W   = 13;
	localparam int DEPTH_OUT_W = 5;

	localparam logic [SYM_W-1:0] SPLIT_RESET = 8'h2C;
	localparam logic [SYM_W-1:0] CH_SQ_OPEN  = 8'h5B;
	localparam logic [SYM_W-1:0] CH_SQ_CLOSE = 8'h5D;
	localparam logic [SYM_W-1:0] CH_CU_OPEN  = 8'h7B;
	localparam logic [SYM_W-1:0] CH_CU_CLOSE = 8'h7D;
	localparam logic [SYM_W-1:0] CH_RD_OPEN  = 8'h28;
	localparam logic [SYM_W-1:0] CH_RD_CLOSE = 8'h29;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_ROUND  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_SQUARE = 3'd1,
		ERR_BAD_CURLY  = 3'd2,
		ERR_BAD_ROUND  = 3'd3,
		ERR_UNCLOSED   = 3'd4,
		ERR_TOO_DEEP   = 3'd5,
		ERR_TOO_LONG   = 3'd6
	} err_t;

	typedef struct packed {
		logic                   segment_valid;
		logic [SEG_START_W-1:0] segment_start;
		logic [SEG_LEN_W-1:0]   segment_length;
		err_t                   error_code;
		logic [DEPTH_OUT_W-1:0] nesting_depth;
		logic                   string_done;
	} res_t;

	function automatic kind_t opener_kind(input logic [SYM_W-1:0] c);
		kind_t k;
		unique case (c)
			CH_SQ_OPEN: k = KIND_SQUARE;
			CH_CU_OPEN: k = KIND_CURLY;
			CH_RD_OPEN: k = KIND_ROUND;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t closer_kind(input logic [SYM_W-1:0] c);
		kind_t k;
		unique case (c)
			CH_SQ_CLOSE: k = KIND_SQUARE;
			CH_CU_CLOSE: k = KIND_CURLY;
			CH_RD_CLOSE: k = KIND_ROUND;
			default:     k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic err_t closer_err(input kind_t k);
		err_t e;
		unique case (k)
			KIND_SQUARE: e = ERR_BAD_SQUARE;
			KIND_CURLY:  e = ERR_BAD_CURLY;
			KIND_ROUND:  e = ERR_BAD_ROUND;
			default:     e = ERR_NONE;
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/bas_intf.sv =====
// Handshake channel interfaces for the bracket-aware splitter.
// Depends on bas_pkg for field widths.
interface bas_cfg_if import bas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] split_symbol;

	modport source (output valid, output split_symbol, input ready);
	modport sink (input valid, input split_symbol, output ready);
endinterface

interface bas_in_if import bas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             final_symbol;

	modport source (output valid, output symbol, output final_symbol, input ready);
	modport sink (input valid, input symbol, input final_symbol, output ready);
endinterface

interface bas_out_if import bas_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   segment_valid;
	logic [SEG_START_W-1:0] segment_start;
	logic [SEG_LEN_W-1:0]   segment_length;
	logic [2:0]             error_code;
	logic [DEPTH_OUT_W-1:0] nesting_depth;
	logic                   string_done;

	modport source (output valid, output segment_valid, output segment_start,
		output segment_length, output error_code, output nesting_depth,
		output string_done, input ready);
	modport sink (input valid, input segment_valid, input segment_start,
		input segment_length, input error_code, input nesting_depth,
		input string_done, output ready);
endinterface

// ===== hdl/bracket_aware_splitter.sv =====
// Bracket-aware splitter: top level with bracket stack, segment tracking
// and a two-entry output buffer. Depends on bas_pkg and bas_intf.
//
// Usage:
//   chr  : one character per item (symbol, final_symbol marks the string end).
//   seg  : one result item per character: segment found, start, length,
//          sticky error, nesting depth after the character, end-of-string echo.
//   cfg  : writes split_symbol; always ready. Write only while the block idles.
// Output: each result is registered before seg offers it.
// Throughput: one character per cycle while chr.ready is high; the bracket
//   kind on top of the stack sits in a register and the entry below it is
//   prefetched from stack memory each cycle: a pop never waits on a read.
// Stall: an output register plus one skid entry; chr.ready drops only when
//   both hold results, and rises again the cycle after seg takes one.
// Reset: depth, position, segment start and error clear; split_symbol
//   returns to ',' (44). Stack memory contents are not cleared; entries are
//   only read after being pushed. The last character of a string also
//   returns the string state to its reset values.
module bracket_aware_splitter import bas_pkg::*; #(
	parameter int MAX_DEPTH  = 16,
	parameter int MAX_LENGTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	bas_cfg_if.sink    cfg,
	bas_in_if.sink     chr,
	bas_out_if.source  seg
);

	localparam int LW = $clog2(MAX_DEPTH + 1);
	localparam int PW = $clog2(MAX_LENGTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [LW-1:0] DEPTH_MAX  = LW'(MAX_DEPTH);
	localparam logic [PW-1:0] LENGTH_MAX = PW'(MAX_LENGTH);

	logic [SYM_W-1:0] split_q;
	logic [LW-1:0]    level_q;
	logic [PW-1:0]    pos_q;
	logic [PW-1:0]    begin_q;
	err_t             sticky_q;
	kind_t            top_q;
	kind_t            rd_q;
	kind_t            stack_mem [MAX_DEPTH];

	res_t out_q;
	res_t skid_q;
	logic out_v_q;
	logic skid_v_q;

	logic          accept;
	logic          out_fire;
	kind_t         ok;
	kind_t         ck;
	err_t          err;
	err_t          err_nx;
	logic          push;
	logic          pop;
	logic [LW-1:0] lvl_nx;
	logic [LW-1:0] lvl_rd;
	logic [PW-1:0] pos_nx;
	logic [PW-1:0] beg_nx;
	logic [PW-1:0] p1;
	logic          seg_v;
	logic [PW-1:0] seg_st;
	logic [PW-1:0] seg_len;
	res_t          res;

	assign accept    = chr.valid && chr.ready;
	assign out_fire  = out_v_q && seg.ready;
	assign chr.ready = !skid_v_q;
	assign cfg.ready = 1'b1;

	always_comb begin
		ok      = opener_kind(chr.symbol);
		ck      = closer_kind(chr.symbol);
		err     = ERR_NONE;
		push    = 1'b0;
		pop     = 1'b0;
		lvl_nx  = level_q;
		pos_nx  = pos_q;
		beg_nx  = begin_q;
		p1      = pos_q + 1'b1;
		seg_v   = 1'b0;
		seg_st  = '0;
		seg_len = '0;
		if (sticky_q == ERR_NONE) begin
			if (pos_q >= LENGTH_MAX) begin
				err = ERR_TOO_LONG;
			end else begin
				if (ok != KIND_NONE) begin
					if (level_q >= DEPTH_MAX) begin
						err = ERR_TOO_DEEP;
					end else begin
						push   = 1'b1;
						lvl_nx = level_q + 1'b1;
					end
				end else if (ck != KIND_NONE) begin
					if (level_q == '0 || top_q != ck) begin
						err = closer_err(ck);
					end else begin
						pop    = 1'b1;
						lvl_nx = level_q - 1'b1;
					end
				end
				if (err == ERR_NONE) begin
					pos_nx = p1;
					if (chr.symbol == split_q && lvl_nx == '0) begin
						if (pos_q > begin_q) begin
							seg_v   = 1'b1;
							seg_st  = begin_q;
							seg_len = pos_q - begin_q;
						end
						beg_nx = p1;
					end
					if (chr.final_symbol) begin
						if (lvl_nx != '0) begin
							err = ERR_UNCLOSED;
						end else if (beg_nx < p1) begin
							seg_v   = 1'b1;
							seg_st  = beg_nx;
							seg_len = p1 - beg_nx;
						end
					end
				end
			end
			if (err != ERR_NONE) begin
				seg_v   = 1'b0;
				seg_st  = '0;
				seg_len = '0;
			end
		end
		err_nx = (sticky_q != ERR_NONE) ? sticky_q : err;

		res.segment_valid  = seg_v;
		res.segment_start  = SEG_START_W'(seg_st);
		res.segment_length = SEG_LEN_W'(seg_len);
		res.error_code     = err_nx;
		res.nesting_depth  = DEPTH_OUT_W'(lvl_nx);
		res.string_done    = chr.final_symbol;
	end

	// prefetch the entry below the next top of stack
	assign lvl_rd = accept ? lvl_nx : level_q;

	always_ff @(posedge clk) begin
		if (accept && push) begin
			stack_mem[AW'(level_q)] <= ok;
		end
		rd_q <= stack_mem[AW'(lvl_rd - LW'(2))];
	end

	always_ff @(posedge clk) begin
		if (accept && push) begin
			top_q <= ok;
		end else if (accept && pop) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= SPLIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			split_q <= cfg.split_symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			pos_q    <= '0;
			begin_q  <= '0;
			sticky_q <= ERR_NONE;
		end else if (accept) begin
			if (chr.final_symbol) begin
				level_q  <= '0;
				pos_q    <= '0;
				begin_q  <= '0;
				sticky_q <= ERR_NONE;
			end else begin
				level_q  <= lvl_nx;
				pos_q    <= pos_nx;
				begin_q  <= beg_nx;
				sticky_q <= err_nx;
			end
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_fire) begin
				skid_v_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_v_q && !out_fire) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_v_q && !out_fire) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign seg.valid          = out_v_q;
	assign seg.segment_valid  = out_q.segment_valid;
	assign seg.segment_start  = out_q.segment_start;
	assign seg.segment_length = out_q.segment_length;
	assign seg.error_code     = out_q.error_code;
	assign seg.nesting_depth  = out_q.nesting_depth;
	assign seg.string_done    = out_q.string_done;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without output entry");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= DEPTH_MAX)
		else $error("stack level beyond maximum depth");

	a_seg_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.segment_valid) |-> (out_q.error_code == ERR_NONE))
		else $error("segment reported with an error");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && chr.final_symbol) |=>
			(level_q == '0 && pos_q == '0 && sticky_q == ERR_NONE))
		else $error("string state not cleared after last item");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE && !(accept && chr.final_symbol)) |=> $stable(sticky_q))
		else $error("sticky error changed before end of string");

endmodule

// ===== dv/bas_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the bracket-aware splitter: watches the cfg, chr and seg
// channels, predicts every seg item from the accepted characters and compares.
// Depends on bas_pkg and the channel interfaces of bas_intf.
module bas_result_checker import bas_pkg::*; #(
	parameter int MAX_DEPTH  = 16,
	parameter int MAX_LENGTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	bas_cfg_if   cfg,
	bas_in_if    chr,
	bas_out_if   seg,
	output int   fail_count,
	output int   pending,
	output int   segments,
	output int   failed_strings
);
	logic [SYM_W-1:0] separator;
	kind_t            open_kinds[MAX_DEPTH];
	int               depth;
	int               position;
	int               segment_from;
	err_t             latched_err;
	res_t             expected_results[$];

	task automatic clear_string();
		depth = 0;
		position = 0;
		segment_from = 0;
		latched_err = ERR_NONE;
	endtask

	task automatic parse_char(input logic [SYM_W-1:0] c, input logic fin, output res_t r);
		kind_t opened;
		kind_t closed;
		err_t  mismatch;
		err_t  fault;
		int    p;
		r = '0;
		opened = KIND_NONE;
		closed = KIND_NONE;
		mismatch = ERR_NONE;
		case (c)
			CH_SQ_OPEN: opened = KIND_SQUARE;
			CH_CU_OPEN: opened = KIND_CURLY;
			CH_RD_OPEN: opened = KIND_ROUND;
			CH_SQ_CLOSE: begin
				closed = KIND_SQUARE;
				mismatch = ERR_BAD_SQUARE;
			end
			CH_CU_CLOSE: begin
				closed = KIND_CURLY;
				mismatch = ERR_BAD_CURLY;
			end
			CH_RD_CLOSE: begin
				closed = KIND_ROUND;
				mismatch = ERR_BAD_ROUND;
			end
			default: ;
		endcase
		if (latched_err == ERR_NONE) begin
			p = position;
			fault = ERR_NONE;
			if (p >= MAX_LENGTH) begin
				fault = ERR_TOO_LONG;
			end else begin
				if (opened != KIND_NONE) begin
					if (depth >= MAX_DEPTH) begin
						fault = ERR_TOO_DEEP;
					end else begin
						open_kinds[depth] = opened;
						depth++;
					end
				end else if (closed != KIND_NONE) begin
					if (depth == 0 || open_kinds[depth-1] != closed)
						fault = mismatch;
					else
						depth--;
				end
				if (fault == ERR_NONE) begin
					position = p + 1;
					// bracket handled first, so a bracket separator sees the new depth
					if (c == separator && depth == 0) begin
						if (p > segment_from) begin
							r.segment_valid = 1'b1;
							r.segment_start = SEG_START_W'(segment_from);
							r.segment_length = SEG_LEN_W'(p - segment_from);
						end
						segment_from = p + 1;
					end
					if (fin) begin
						if (depth != 0) begin
							fault = ERR_UNCLOSED;
						end else if (segment_from < p + 1) begin
							r.segment_valid = 1'b1;
							r.segment_start = SEG_START_W'(segment_from);
							r.segment_length = SEG_LEN_W'(p + 1 - segment_from);
						end
					end
				end
			end
			if (fault != ERR_NONE) begin
				latched_err = fault;
				r.segment_valid = 1'b0;
				r.segment_start = '0;
				r.segment_length = '0;
			end
		end
		r.error_code = latched_err;
		r.nesting_depth = DEPTH_OUT_W'(depth);
		r.string_done = fin;
		if (fin)
			clear_string();
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t next;
		if (!arst_n) begin
			separator = SPLIT_RESET;
			clear_string();
			expected_results.delete();
			fail_count = 0;
			segments = 0;
			failed_strings = 0;
			pending <= 0;
		end else begin
			if (seg.valid && seg.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing pending, expected none, %s %0d/%0d/%0d/%0d/%0d/%0d",
						$time, "actual", seg.segment_valid, seg.segment_start,
						seg.segment_length, seg.error_code, seg.nesting_depth,
						seg.string_done);
				end else begin
					want = expected_results.pop_front();
					check_field("segment_valid", want.segment_valid, seg.segment_valid);
					check_field("segment_start", want.segment_start, seg.segment_start);
					check_field("segment_length", want.segment_length, seg.segment_length);
					check_field("error_code", want.error_code, seg.error_code);
					check_field("nesting_depth", want.nesting_depth, seg.nesting_depth);
					check_field("string_done", want.string_done, seg.string_done);
				end
			end
			if (cfg.valid && cfg.ready)
				separator = cfg.split_symbol;
			if (chr.valid && chr.ready) begin
				parse_char(chr.symbol, chr.final_symbol, next);
				if (next.segment_valid)
					segments++;
				if (next.string_done && next.error_code != ERR_NONE)
					failed_strings++;
				expected_results.insert(expected_results.size(), next);
			end
			pending <= expected_results.size();
		end
	end
endmodule

// ===== dv/tb_bracket_aware_splitter.sv =====
`timescale 1ns / 1ps
// Testbench top for the bracket-aware splitter: drives characters and separator
// writes with random idling, stalls the result side, and reports the verdict.
// Depends on bas_pkg, bas_intf, the splitter RTL and bas_result_checker.
module tb_bracket_aware_splitter import bas_pkg::*; ();

	localparam int     HOLD_CYCLES  = 300;
	localparam int     SETTLE       = 4;
	localparam int     RANDOM_ITEMS = 950;
	localparam int     PHASES       = 6;
	localparam int     MAX_NEST     = 16;
	localparam longint LIMIT        = 1_500_000;

	localparam logic [7:0] OPENERS[3] = '{CH_SQ_OPEN, CH_CU_OPEN, CH_RD_OPEN};
	localparam logic [7:0] CLOSERS[3] = '{CH_SQ_CLOSE, CH_CU_CLOSE, CH_RD_CLOSE};

	logic   clk = 1'b0;
	logic   arst_n;
	int     fail_count;
	int     pending;
	int     segments;
	int     failed_strings;
	int     chars_sent;
	int     strings_sent;
	int     random_chars;
	longint cycle_count;
	bit     tx_calm;
	bit     rx_calm;
	bit     hold_long;
	logic [7:0] sep;
	logic [7:0] text[$];

	bas_cfg_if cfg_ch ();
	bas_in_if  chr_ch ();
	bas_out_if seg_ch ();

	bracket_aware_splitter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.chr(chr_ch),
		.seg(seg_ch)
	);

	bas_result_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.chr(chr_ch),
		.seg(seg_ch),
		.fail_count(fail_count),
		.pending(pending),
		.segments(segments),
		.failed_strings(failed_strings)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic put_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			chr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chr_ch.valid <= 1'b1;
		chr_ch.symbol <= c;
		chr_ch.final_symbol <= fin;
		do @(posedge clk); while (!chr_ch.ready);
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			put_char(text[i], i == text.size() - 1);
		chars_sent += text.size();
		strings_sent++;
		text.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text.insert(text.size(), s[i]);
	endtask

	task automatic add_run(input logic [7:0] c, input int n);
		repeat (n) text.insert(text.size(), c);
	endtask

	function automatic logic [7:0] filler();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c inside {CH_SQ_OPEN, CH_CU_OPEN, CH_RD_OPEN, CH_SQ_CLOSE, CH_CU_CLOSE, CH_RD_CLOSE})
			c = 8'h61;
		return c;
	endfunction

	// balanced brackets with random content; close_all=0 leaves them open
	task automatic grow_text(input int n, input bit close_all);
		logic [7:0] closers[$];
		int r;
		int k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2 && closers.size() < MAX_NEST) begin
				k = $urandom_range(0, 2);
				text.insert(text.size(), OPENERS[k]);
				closers.insert(closers.size(), CLOSERS[k]);
			end else if (r < 4 && closers.size() > 0) begin
				text.insert(text.size(), closers.pop_back());
			end else if (r < 6) begin
				text.insert(text.size(), sep);
			end else begin
				text.insert(text.size(), filler());
			end
		end
		if (close_all)
			while (closers.size() > 0)
				text.insert(text.size(), closers.pop_back());
	endtask

	task automatic nest_text(input int levels);
		logic [7:0] closers[$];
		int k;
		for (int i = 0; i < levels; i++) begin
			k = $urandom_range(0, 2);
			text.insert(text.size(), OPENERS[k]);
			closers.insert(closers.size(), CLOSERS[k]);
		end
		text.insert(text.size(), sep);
		while (closers.size() > 0)
			text.insert(text.size(), closers.pop_back());
	endtask

	task automatic send_random_string();
		int shape;
		int n;
		tx_calm = ($urandom_range(0, 3) == 0);
		shape = $urandom_range(0, 19);
		n = $urandom_range(1, 20);
		if (shape < 14) begin
			grow_text(n, 1'b1);
		end else if (shape < 16) begin
			for (int i = 0; i < n; i++)
				text.insert(text.size(), ($urandom_range(0, 2) == 0) ?
					CLOSERS[$urandom_range(0, 2)] : 8'($urandom_range(0, 255)));
		end else if (shape == 16) begin
			grow_text(n, 1'b1);
			text.insert($urandom_range(0, text.size()), CLOSERS[$urandom_range(0, 2)]);
		end else if (shape == 17) begin
			text.insert(text.size(), OPENERS[$urandom_range(0, 2)]);
			grow_text(n, 1'b0);
		end else if (shape == 18) begin
			nest_text($urandom_range(14, 18));
		end else begin
			for (int i = 0; i < n; i++)
				text.insert(text.size(), ($urandom_range(0, 1) == 1) ? sep : filler());
		end
		random_chars += text.size();
		send_text();
	endtask

	task automatic drain();
		chr_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_separator(input logic [7:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.split_symbol <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sep = v;
	endtask

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// result side: random stalls, calm stretches, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				seg_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else begin
				gap = rx_calm ? 0 : $urandom_range(0, 9);
				if (gap > 0) begin
					seg_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			seg_ch.ready <= 1'b1;
			do @(posedge clk); while (!seg_ch.valid);
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
		end
	end

	initial begin
		logic [7:0] phase_sep[PHASES];
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.split_symbol = '0;
		chr_ch.valid = 1'b0;
		chr_ch.symbol = '0;
		chr_ch.final_symbol = 1'b0;
		seg_ch.ready = 1'b0;
		sep = SPLIT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all brackets, separator in and out of brackets, each bracket mismatch and an unclosed string
		add_str("[a,{b}](c),d");
		send_text();
		add_str(",");
		send_text();
		add_str("]");
		send_text();
		add_str("{)x");
		send_text();
		add_str("(}");
		send_text();
		add_str("(");
		send_text();
		text.insert(text.size(), 8'h00);
		text.insert(text.size(), 8'hFF);
		send_text();

		// depth limit
		tx_calm = 1'b1;
		add_run(CH_CU_OPEN, MAX_NEST);
		add_run(CH_CU_CLOSE, MAX_NEST);
		send_text();
		add_run(CH_SQ_OPEN, MAX_NEST + 1);
		send_text();

		phase_sep = '{SPLIT_RESET, 8'h00, 8'hFF, CH_RD_CLOSE, CH_SQ_OPEN,
			8'($urandom_range(0, 255))};
		for (int ph = 0; ph < PHASES; ph++) begin
			set_separator(phase_sep[ph]);
			if (phase_sep[ph] == CH_RD_CLOSE) begin
				add_str("(a)b");
				send_text();
				add_str("x)");
				send_text();
			end else if (phase_sep[ph] == CH_SQ_OPEN) begin
				add_str("a[b]c");
				send_text();
			end
			if (ph == 1) begin
				// fill the block while results are held back
				hold_long = 1'b1;
				tx_calm = 1'b1;
				grow_text(40, 1'b1);
				send_text();
			end
			while (random_chars < (RANDOM_ITEMS * (ph + 1)) / PHASES) begin
				send_random_string();
				if (ph == 3 && strings_sent % 25 == 0)
					drain();
			end
		end

		drain();
		$display("checked %0d strings, %0d characters, %0d segments, %0d strings ending in error",
			strings_sent, chars_sent, segments, failed_strings);
		$display("separators: comma, 0x00, 0xff, ')', '[' and one random; one %0d-cycle result hold-off",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/bas_pkg.sv
hdl/bas_intf.sv
hdl/bracket_aware_splitter.sv
dv/bas_result_checker.sv
dv/tb_bracket_aware_splitter.sv
